// ===== rtl/cce_pkg.sv =====
// shared types, constants and helpers for the capital conversion encoder
package cce_pkg;

  // character codes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_SMALL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_BIG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRLF      = 3'd4;

  // most bytes one request can produce
  localparam int unsigned MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_SMALL = 2'd1,
    MODE_BIG   = 2'd2,
    MODE_FIRST = 2'd3
  } mode_t;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_payload_t;

  // bytes produced by one request, cnt counts valid entries from index 0
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } bundle_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic letter_is_caps(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic letter_is_small(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  // append one byte to a bundle, dropping anything past the limit
  function automatic bundle_t push_byte(input bundle_t b, input logic [7:0] v);
    bundle_t r;
    r = b;
    if (b.cnt < 3'(MAX_RESULTS)) begin
      r.bytes[b.cnt[1:0]] = v;
      r.cnt = b.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cce_front.sv =====
// front part: marker registers, segment state and per-request byte bundle
module cce_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cce_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cce_pkg::in_payload_t         in_data,
  input  cce_pkg::q_status_t           q_status,
  output logic                         push,
  output cce_pkg::bundle_t             push_data
);
  import cce_pkg::*;

  logic [7:0] m_small_r, m_big_r, m_first_r, m_esc_r, m_crlf_r;
  mode_t      mode_r, mode_nxt;
  logic [7:0] held_upper_r, held_upper_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       cr_pending_r, cr_pending_nxt;
  bundle_t    bundle;
  logic       accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (bundle.cnt != 3'd0);
  assign push_data = bundle;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_small_r <= 8'd1;
      m_big_r   <= 8'd2;
      m_first_r <= 8'd3;
      m_esc_r   <= 8'd4;
      m_crlf_r  <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ALL_SMALL: m_small_r <= cfg_wdata;
        REG_ALL_BIG:   m_big_r   <= cfg_wdata;
        REG_FIRST_BIG: m_first_r <= cfg_wdata;
        REG_ESCAPE:    m_esc_r   <= cfg_wdata;
        REG_CRLF:      m_crlf_r  <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // classify the byte and build its output bundle
  always_comb begin
    logic [7:0] c;
    logic       do_handle;
    c              = in_data.byte_value;
    do_handle      = 1'b0;
    mode_nxt       = mode_r;
    held_upper_nxt = held_upper_r;
    held_valid_nxt = held_valid_r;
    cr_pending_nxt = cr_pending_r;
    bundle         = '0;

    if (in_data.command) begin
      // flush: close the word, then any waiting cr
      if (held_valid_nxt) begin
        bundle = push_byte(bundle, m_first_r);
        bundle = push_byte(bundle, held_upper_nxt | CASE_BIT);
        held_valid_nxt = 1'b0;
      end
      mode_nxt = MODE_NONE;
      if (cr_pending_nxt) begin
        bundle = push_byte(bundle, CH_CR);
        cr_pending_nxt = 1'b0;
      end
    end else if (cr_pending_nxt) begin
      cr_pending_nxt = 1'b0;
      if (c == CH_LF) begin
        bundle = push_byte(bundle, m_crlf_r);
      end else begin
        bundle = push_byte(bundle, CH_CR);
        do_handle = 1'b1;
      end
    end else if (c == CH_CR) begin
      if (held_valid_nxt) begin
        bundle = push_byte(bundle, m_first_r);
        bundle = push_byte(bundle, held_upper_nxt | CASE_BIT);
        held_valid_nxt = 1'b0;
      end
      mode_nxt = MODE_NONE;
      cr_pending_nxt = 1'b1;
    end else begin
      do_handle = 1'b1;
    end

    // ordinary byte handling
    if (do_handle) begin
      if (letter_is_caps(c)) begin
        if (held_valid_nxt) begin
          bundle = push_byte(bundle, m_big_r);
          bundle = push_byte(bundle, held_upper_nxt | CASE_BIT);
          bundle = push_byte(bundle, c | CASE_BIT);
          held_valid_nxt = 1'b0;
          mode_nxt = MODE_BIG;
        end else if (mode_nxt == MODE_BIG) begin
          bundle = push_byte(bundle, c | CASE_BIT);
        end else begin
          held_upper_nxt = c;
          held_valid_nxt = 1'b1;
        end
      end else if (letter_is_small(c)) begin
        if (held_valid_nxt) begin
          bundle = push_byte(bundle, m_first_r);
          bundle = push_byte(bundle, held_upper_nxt | CASE_BIT);
          bundle = push_byte(bundle, c);
          held_valid_nxt = 1'b0;
          mode_nxt = MODE_FIRST;
        end else if (mode_nxt == MODE_BIG) begin
          bundle = push_byte(bundle, m_small_r);
          bundle = push_byte(bundle, c);
          mode_nxt = MODE_SMALL;
        end else begin
          if (mode_nxt == MODE_NONE) begin
            mode_nxt = MODE_SMALL;
          end
          bundle = push_byte(bundle, c);
        end
      end else begin
        // non-letter closes the word and may need an escape
        if (held_valid_nxt) begin
          bundle = push_byte(bundle, m_first_r);
          bundle = push_byte(bundle, held_upper_nxt | CASE_BIT);
          held_valid_nxt = 1'b0;
        end
        mode_nxt = MODE_NONE;
        if (c == m_small_r || c == m_big_r || c == m_first_r ||
            c == m_esc_r || c == m_crlf_r) begin
          bundle = push_byte(bundle, m_esc_r);
        end
        bundle = push_byte(bundle, c);
      end
    end
  end

  // segment state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NONE;
      held_valid_r <= 1'b0;
      cr_pending_r <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      held_valid_r <= held_valid_nxt;
      cr_pending_r <= cr_pending_nxt;
    end
  end

  // held capital
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_upper_r <= 8'h00;
    end else if (accept) begin
      held_upper_r <= held_upper_nxt;
    end
  end

endmodule

// ===== rtl/cce_queue.sv =====
// bundle queue between the front and back parts
module cce_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cce_pkg::bundle_t   push_data,
  input  logic               pop,
  output cce_pkg::bundle_t   rd_data,
  output cce_pkg::q_status_t status
);
  import cce_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t            slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rd_data      = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/cce_back.sv =====
// back part: unpacks bundles into single bytes behind an output register
module cce_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cce_pkg::q_status_t    q_status,
  input  cce_pkg::bundle_t      q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cce_pkg::out_payload_t out_data
);
  import cce_pkg::*;

  bundle_t      cur_r;
  logic         cur_valid_r;
  logic [1:0]   idx_r;
  logic         out_valid_r;
  out_payload_t out_data_r;
  logic         advance, take, cur_last, load;

  assign advance  = !out_valid_r || out_ready;
  assign take     = cur_valid_r && advance;
  assign cur_last = ({1'b0, idx_r} == (cur_r.cnt - 3'd1));
  assign load     = (!cur_valid_r || (take && cur_last)) && !q_status.empty;
  assign pop      = load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // current bundle and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (take && cur_last) begin
      cur_valid_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.out_byte <= cur_r.bytes[idx_r];
      out_data_r.last     <= cur_last;
    end
  end

endmodule

// ===== rtl/capital_conversion_encoder_core.sv =====
// top level of the capital conversion encoder
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    command, byte_value
//  out_     output     out_valid/out_ready  out_byte, last
//  cfg_     input      cfg_we               cfg_idx, cfg_wdata (8 bits)
//
// one request is taken per cycle while the bundle queue has room; the front
// part turns it into up to four bytes in that cycle, and the back part sends
// one byte per cycle while out_ready allows, so a request yields zero to four
// output bytes. a byte passes the queue, current-bundle and output registers.
// reset is synchronous and clears state and queue; markers return to 1..5.
// out_ready low fills the queue of QUEUE_DEPTH bundles, then in_ready drops.
module capital_conversion_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cce_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cce_pkg::in_payload_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cce_pkg::out_payload_t         out_data
);
  import cce_pkg::*;

  q_status_t q_status;
  logic      push, pop;
  bundle_t   push_data, q_data;

  // classify and build bundles
  cce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  cce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (q_data),
    .status    (q_status)
  );

  // serialize bytes
  cce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
